FILE: sv/hpr_pkg.sv
// Shared types and constants for the harmonic position restraint block.
package hpr_pkg;

  localparam int NumParticles = 4096;
  localparam int RefAw = (NumParticles > 1) ? $clog2(NumParticles) : 1;

  localparam int TagW    = 12;
  localparam int PosW    = 32;
  localparam int StiffW  = 32;
  localparam int BoxW    = 31;
  localparam int EnergyW = 48;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 32;

  localparam int DrW    = PosW + 2;
  localparam int MagW   = PosW + 1;
  localparam int ProdW  = StiffW + MagW;
  localparam int ETermW = ProdW + MagW;

  typedef enum logic {
    ACT_COMPUTE = 1'b0,
    ACT_STORE   = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STIFF_X = 3'd0,
    REG_STIFF_Y = 3'd1,
    REG_STIFF_Z = 3'd2,
    REG_BOX_X   = 3'd3,
    REG_BOX_Y   = 3'd4,
    REG_BOX_Z   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic diff;
    logic wrap;
    logic mag;
    logic mul1;
    logic mlo;
    logic mhi;
    logic acc;
    logic sum1;
    logic sum2;
  } hpr_step_t;

endpackage

FILE: sv/hpr_if.sv
// Handshake channel interfaces: item input, result output, register write.
interface hpr_in_if import hpr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [TagW-1:0]        particle_tag;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;

  modport source(output valid, action, particle_tag, pos_x, pos_y, pos_z, input ready);
  modport sink(input valid, action, particle_tag, pos_x, pos_y, pos_z, output ready);
endinterface

interface hpr_out_if import hpr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [TagW-1:0]        out_tag;
  logic signed [PosW-1:0] force_x;
  logic signed [PosW-1:0] force_y;
  logic signed [PosW-1:0] force_z;
  logic [EnergyW-1:0]     energy;

  modport source(output valid, out_tag, force_x, force_y, force_z, energy, input ready);
  modport sink(input valid, out_tag, force_x, force_y, force_z, energy, output ready);
endinterface

interface hpr_cfg_if import hpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/harmonic_position_restraint_top.sv
// Harmonic position restraint: a store beat (action 1) writes the reference
// position of one tag into the table. A compute beat (action 0) reads the
// reference, and three axis lanes each form the minimum-image displacement,
// the force -k*dr and k*dr^2; a merge stage sums and scales the energy. A
// compute beat runs through the accept state, which also reads the table,
// then the chain of subtract, wrap, magnitude, three partial multiplies and
// accumulate in each lane and two energy sums in the merge stage; no new
// beat is accepted until the chain is through. The result sits in an output
// register, so input is taken again while it waits; a second result is held
// in the last sum stage, with the input stalled, until the first is taken.
// The reference table has no reset; read a tag only after storing it.
module harmonic_position_restraint_top import hpr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  hpr_in_if.sink    in_i,
  hpr_out_if.source out_o,
  hpr_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_WRAP, ST_MAG, ST_MUL1, ST_MLO, ST_MHI, ST_ACC,
    ST_SUM1, ST_SUM2
  } state_e;

  state_e                 state_q;
  logic                   out_valid_q;
  logic [TagW-1:0]        tag_q;
  logic [TagW-1:0]        out_tag_q;
  logic                   inr_q;
  logic signed [PosW-1:0] pos_q [3];
  logic signed [PosW-1:0] out_force_q [3];
  logic [3*PosW-1:0]      ref_mem_q [NumParticles];
  logic [3*PosW-1:0]      rd_q;
  logic [StiffW-1:0]      stiff_q [3];
  logic [BoxW-1:0]        box_q [3];
  logic signed [PosW-1:0] ref_w [3];
  logic signed [PosW-1:0] force_w [3];
  logic [ETermW-1:0]      eterm_w [3];
  logic [EnergyW-1:0]     energy_w;
  logic                   in_acc;
  logic                   in_range;
  logic                   out_free;
  logic                   sum2_go;
  logic [RefAw-1:0]       addr;
  hpr_step_t              step;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign in_range    = 32'(in_i.particle_tag) < NumParticles;
  assign addr        = RefAw'(in_i.particle_tag);
  assign out_free    = !out_valid_q || out_o.ready;
  assign sum2_go     = (state_q == ST_SUM2) && out_free;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    step      = '0;
    step.diff = (state_q == ST_DIFF);
    step.wrap = (state_q == ST_WRAP);
    step.mag  = (state_q == ST_MAG);
    step.mul1 = (state_q == ST_MUL1);
    step.mlo  = (state_q == ST_MLO);
    step.mhi  = (state_q == ST_MHI);
    step.acc  = (state_q == ST_ACC);
    step.sum1 = (state_q == ST_SUM1);
    step.sum2 = sum2_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        stiff_q[i] <= '0;
        box_q[i]   <= '0;
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_STIFF_X: stiff_q[0] <= cfg_i.data;
        REG_STIFF_Y: stiff_q[1] <= cfg_i.data;
        REG_STIFF_Z: stiff_q[2] <= cfg_i.data;
        REG_BOX_X:   box_q[0]   <= cfg_i.data[BoxW-1:0];
        REG_BOX_Y:   box_q[1]   <= cfg_i.data[BoxW-1:0];
        REG_BOX_Z:   box_q[2]   <= cfg_i.data[BoxW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (in_i.action == ACT_STORE) begin
        if (in_range) begin
          ref_mem_q[addr] <= {in_i.pos_z, in_i.pos_y, in_i.pos_x};
        end
      end else begin
        rd_q <= ref_mem_q[addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_i.action == ACT_COMPUTE)) begin
      tag_q    <= in_i.particle_tag;
      inr_q    <= in_range;
      pos_q[0] <= in_i.pos_x;
      pos_q[1] <= in_i.pos_y;
      pos_q[2] <= in_i.pos_z;
    end
    if (sum2_go) begin
      out_tag_q <= tag_q;
      for (int i = 0; i < 3; i++) begin
        out_force_q[i] <= force_w[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (sum2_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_i.action == ACT_COMPUTE)) begin
            state_q <= ST_DIFF;
          end
        end
        ST_DIFF: state_q <= ST_WRAP;
        ST_WRAP: state_q <= ST_MAG;
        ST_MAG:  state_q <= ST_MUL1;
        ST_MUL1: state_q <= ST_MLO;
        ST_MLO:  state_q <= ST_MHI;
        ST_MHI:  state_q <= ST_ACC;
        ST_ACC:  state_q <= ST_SUM1;
        ST_SUM1: state_q <= ST_SUM2;
        ST_SUM2: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign ref_w[g] = inr_q ? signed'(rd_q[g*PosW +: PosW]) : '0;

    hpr_lane u_lane (
      .clk_i     (clk_i),
      .step_i    (step),
      .pos_i     (pos_q[g]),
      .ref_i     (ref_w[g]),
      .box_len_i (box_q[g]),
      .stiff_i   (stiff_q[g]),
      .force_o   (force_w[g]),
      .eterm_o   (eterm_w[g])
    );
  end

  hpr_merge u_merge (
    .clk_i     (clk_i),
    .step_i    (step),
    .eterm_x_i (eterm_w[0]),
    .eterm_y_i (eterm_w[1]),
    .eterm_z_i (eterm_w[2]),
    .energy_o  (energy_w)
  );

  assign out_o.valid   = out_valid_q;
  assign out_o.out_tag = out_tag_q;
  assign out_o.force_x = out_force_q[0];
  assign out_o.force_y = out_force_q[1];
  assign out_o.force_z = out_force_q[2];
  assign out_o.energy  = energy_w;

`ifndef SYNTH
  a_rose_after_sum2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SUM2))
    else $error("result valid without final sum");

  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.action == ACT_COMPUTE)) |=> (state_q == ST_DIFF))
    else $error("compute beat did not start the lanes");

  a_store_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.action == ACT_STORE)) |=> (state_q == ST_IDLE))
    else $error("store beat left idle");

  a_sum2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SUM2) && out_valid_q && !out_o.ready) |=>
      ((state_q == ST_SUM2) && out_valid_q))
    else $error("pending result overwritten");
`endif

endmodule

FILE: sv/hpr_lane.sv
// One axis lane: displacement, minimum image, force and k*dr^2 term.
module hpr_lane import hpr_pkg::*; (
  input  logic                   clk_i,
  input  hpr_step_t              step_i,
  input  logic signed [PosW-1:0] pos_i,
  input  logic signed [PosW-1:0] ref_i,
  input  logic [BoxW-1:0]        box_len_i,
  input  logic [StiffW-1:0]      stiff_i,
  output logic signed [PosW-1:0] force_o,
  output logic [ETermW-1:0]      eterm_o
);

  logic signed [DrW-1:0]   dr_q;
  logic signed [DrW:0]     twice;
  logic signed [DrW:0]     len_w;
  logic signed [DrW-1:0]   len_s;
  logic [MagW-1:0]         mag_q;
  logic                    pos_q;
  logic [ProdW-1:0]        prod_q;
  logic [ProdW-17:0]       quo;
  logic [ProdW-1:0]        mlo_q;
  logic [ProdW:0]          mhi_q;
  logic signed [PosW-1:0]  force_q;
  logic signed [PosW-1:0]  force_d;
  logic [ETermW-1:0]       eterm_q;

  assign twice = {dr_q, 1'b0};
  assign len_w = signed'({{(DrW+1-BoxW){1'b0}}, box_len_i});
  assign len_s = signed'({{(DrW-BoxW){1'b0}}, box_len_i});
  assign quo   = prod_q[ProdW-1:16];

  always_comb begin
    if (pos_q) begin
      if (quo > (ProdW-16)'(33'h0_8000_0000)) begin
        force_d = signed'(32'h8000_0000);
      end else begin
        force_d = signed'(PosW'(-quo));
      end
    end else begin
      if (quo > (ProdW-16)'(33'h0_7FFF_FFFF)) begin
        force_d = signed'(32'h7FFF_FFFF);
      end else begin
        force_d = signed'(quo[PosW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.diff) begin
      dr_q <= DrW'(pos_i) - DrW'(ref_i);
    end
    if (step_i.wrap) begin
      if (twice >= len_w) begin
        dr_q <= dr_q - len_s;
      end else if (twice < -len_w) begin
        dr_q <= dr_q + len_s;
      end
    end
    if (step_i.mag) begin
      mag_q <= dr_q[DrW-1] ? MagW'(-dr_q) : MagW'(dr_q);
      pos_q <= !dr_q[DrW-1] && (dr_q != '0);
    end
    if (step_i.mul1) begin
      prod_q <= ProdW'(stiff_i) * ProdW'(mag_q);
    end
    if (step_i.mlo) begin
      mlo_q   <= ProdW'(prod_q[31:0]) * ProdW'(mag_q);
      force_q <= force_d;
    end
    if (step_i.mhi) begin
      mhi_q <= (ProdW+1)'(prod_q[ProdW-1:32]) * (ProdW+1)'(mag_q);
    end
    if (step_i.acc) begin
      eterm_q <= ETermW'(mlo_q) + {mhi_q, 32'b0};
    end
  end

  assign force_o = force_q;
  assign eterm_o = eterm_q;

endmodule

FILE: sv/hpr_merge.sv
// Merge stage: sums the three axis energy terms, halves, rescales, saturates.
module hpr_merge import hpr_pkg::*; (
  input  logic                clk_i,
  input  hpr_step_t           step_i,
  input  logic [ETermW-1:0]   eterm_x_i,
  input  logic [ETermW-1:0]   eterm_y_i,
  input  logic [ETermW-1:0]   eterm_z_i,
  output logic [EnergyW-1:0]  energy_o
);

  localparam int ShiftE = 33;

  logic [ETermW:0]      sum_q;
  logic [ETermW+1:0]    total;
  logic [EnergyW-1:0]   energy_q;

  assign total = (ETermW+2)'(sum_q) + (ETermW+2)'(eterm_z_i);

  always_ff @(posedge clk_i) begin
    if (step_i.sum1) begin
      sum_q <= (ETermW+1)'(eterm_x_i) + (ETermW+1)'(eterm_y_i);
    end
    if (step_i.sum2) begin
      if (|total[ETermW+1:ShiftE+EnergyW]) begin
        energy_q <= '1;
      end else begin
        energy_q <= total[ShiftE+EnergyW-1:ShiftE];
      end
    end
  end

  assign energy_o = energy_q;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for harmonic_position_restraint_top: reference stores, force checks.
`timescale 1ns / 1ps

typedef struct packed {
  logic [hpr_pkg::TagW-1:0]        tag;
  logic signed [hpr_pkg::PosW-1:0] fx;
  logic signed [hpr_pkg::PosW-1:0] fy;
  logic signed [hpr_pkg::PosW-1:0] fz;
  logic [hpr_pkg::EnergyW-1:0]     energy;
} restraint_result_t;

class restraint_scoreboard;
  localparam logic signed [hpr_pkg::PosW-1:0] MinForce = 32'sh8000_0000;
  localparam logic signed [hpr_pkg::PosW-1:0] MaxForce = 32'sh7FFF_FFFF;

  logic signed [hpr_pkg::PosW-1:0] ref_tab [hpr_pkg::NumParticles][3];
  logic [hpr_pkg::StiffW-1:0]      stiffness [3];
  logic [hpr_pkg::BoxW-1:0]        box_len [3];
  restraint_result_t               expected_forces [$];
  int errors, n_stores, n_results, n_wraps, n_sat;

  function new();
    for (int a = 0; a < 3; a++) begin
      stiffness[a] = '0;
      box_len[a]   = '0;
    end
  endfunction

  function void write_reg(logic [hpr_pkg::CfgIdxW-1:0] idx, logic [hpr_pkg::CfgW-1:0] data);
    case (idx)
      hpr_pkg::REG_STIFF_X: stiffness[0] = data;
      hpr_pkg::REG_STIFF_Y: stiffness[1] = data;
      hpr_pkg::REG_STIFF_Z: stiffness[2] = data;
      hpr_pkg::REG_BOX_X:   box_len[0] = data[hpr_pkg::BoxW-1:0];
      hpr_pkg::REG_BOX_Y:   box_len[1] = data[hpr_pkg::BoxW-1:0];
      hpr_pkg::REG_BOX_Z:   box_len[2] = data[hpr_pkg::BoxW-1:0];
      default: ;
    endcase
  endfunction

  function restraint_result_t predict_force(logic [hpr_pkg::TagW-1:0] tag,
                                            logic signed [hpr_pkg::PosW-1:0] x,
                                            logic signed [hpr_pkg::PosW-1:0] y,
                                            logic signed [hpr_pkg::PosW-1:0] z);
    logic signed [hpr_pkg::PosW-1:0] pos [3];
    logic signed [hpr_pkg::PosW-1:0] f [3];
    longint dr, len;
    logic [127:0] k_w, mag_w, prod, q, e_sum, e_q;
    restraint_result_t r;
    pos[0] = x;
    pos[1] = y;
    pos[2] = z;
    e_sum = '0;
    for (int a = 0; a < 3; a++) begin
      dr  = longint'(pos[a]) - longint'(ref_tab[tag][a]);
      len = longint'(box_len[a]);
      // single minimum-image fold
      if (2 * dr >= len) begin
        dr = dr - len;
        if (len != 0) n_wraps++;
      end else if (2 * dr < -len) begin
        dr = dr + len;
        if (len != 0) n_wraps++;
      end
      mag_w = (dr < 0) ? 128'(-dr) : 128'(dr);
      k_w   = 128'(stiffness[a]);
      prod  = k_w * mag_w;
      q     = prod >> 16;
      if (dr > 0) begin
        if (q > 128'h8000_0000) begin
          f[a] = MinForce;
          n_sat++;
        end else begin
          f[a] = -q[hpr_pkg::PosW-1:0];
        end
      end else begin
        if (q > 128'h7FFF_FFFF) begin
          f[a] = MaxForce;
          n_sat++;
        end else begin
          f[a] = q[hpr_pkg::PosW-1:0];
        end
      end
      e_sum = e_sum + prod * mag_w;
    end
    e_q      = e_sum >> 33;
    r.tag    = tag;
    r.fx     = f[0];
    r.fy     = f[1];
    r.fz     = f[2];
    r.energy = (e_q > 128'hFFFF_FFFF_FFFF) ? '1 : e_q[hpr_pkg::EnergyW-1:0];
    return r;
  endfunction

  function void note_input(logic act, logic [hpr_pkg::TagW-1:0] tag,
                           logic signed [hpr_pkg::PosW-1:0] x,
                           logic signed [hpr_pkg::PosW-1:0] y,
                           logic signed [hpr_pkg::PosW-1:0] z);
    if (act == hpr_pkg::ACT_STORE) begin
      ref_tab[tag][0] = x;
      ref_tab[tag][1] = y;
      ref_tab[tag][2] = z;
      n_stores++;
    end else begin
      expected_forces = {expected_forces, predict_force(tag, x, y, z)};
    end
  endfunction

  function void cmp_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(restraint_result_t got);
    restraint_result_t want;
    if (expected_forces.size() == 0) begin
      $error("unexpected result beat for tag %0d", got.tag);
      errors++;
      return;
    end
    want = expected_forces.pop_front();
    n_results++;
    cmp_field("out_tag", want.tag, got.tag);
    cmp_field("force_x", want.fx, got.fx);
    cmp_field("force_y", want.fy, got.fy);
    cmp_field("force_z", want.fz, got.fz);
    cmp_field("energy", want.energy, got.energy);
  endfunction

  function int pending();
    return expected_forces.size();
  endfunction
endclass

module tb_top;
  import hpr_pkg::*;

  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 24;
  localparam int LongHold     = 300;
  localparam int SegItems     = 325;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  hpr_in_if  in_if();
  hpr_out_if out_if();
  hpr_cfg_if cfg_if();

  harmonic_position_restraint_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  restraint_scoreboard forces_sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int stored_tags [$];
  bit [NumParticles-1:0] tag_written = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      forces_sb.note_input(in_if.action, in_if.particle_tag, in_if.pos_x, in_if.pos_y,
                           in_if.pos_z);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      forces_sb.check_result('{tag: out_if.out_tag, fx: out_if.force_x, fy: out_if.force_y,
                               fz: out_if.force_z, energy: out_if.energy});
  end

  // result side: random stalls plus requested long hold-offs
  always @(negedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_item(action_e act, logic [TagW-1:0] tag, logic signed [PosW-1:0] x,
                           logic signed [PosW-1:0] y, logic signed [PosW-1:0] z);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= act;
    in_if.particle_tag <= tag;
    in_if.pos_x        <= x;
    in_if.pos_y        <= y;
    in_if.pos_z        <= z;
    if (act == ACT_STORE && !tag_written[tag]) begin
      tag_written[tag] = 1'b1;
      stored_tags = {stored_tags, int'(tag)};
    end
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_forces_drained();
    in_if.valid <= 1'b0;
    while (forces_sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    forces_sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic configure(logic [CfgW-1:0] kx, logic [CfgW-1:0] ky, logic [CfgW-1:0] kz,
                           logic [CfgW-1:0] bx, logic [CfgW-1:0] by, logic [CfgW-1:0] bz);
    write_reg(REG_STIFF_X, kx);
    write_reg(REG_STIFF_Y, ky);
    write_reg(REG_STIFF_Z, kz);
    write_reg(REG_BOX_X, bx);
    write_reg(REG_BOX_Y, by);
    write_reg(REG_BOX_Z, bz);
    // unmapped indexes go last so a wrong decode would clobber a live register
    write_reg(RegSpareLo, $urandom());
    write_reg(RegSpareHi, $urandom());
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_item();
    logic [TagW-1:0] tag;
    logic signed [PosW-1:0] p [3];
    logic signed [PosW-1:0] ref_v, delta;
    int mode;
    if ($urandom_range(0, 99) < 30) begin
      tag = $urandom_range(0, 1) ? TagW'($urandom_range(0, 15))
                                 : TagW'($urandom_range(0, NumParticles - 1));
      for (int a = 0; a < 3; a++) p[a] = $urandom();
      send_item(ACT_STORE, tag, p[0], p[1], p[2]);
    end else begin
      tag  = TagW'(stored_tags[$urandom_range(0, stored_tags.size() - 1)]);
      mode = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
        ref_v = forces_sb.ref_tab[tag][a];
        if (mode < 4) begin
          p[a] = ref_v + $signed($urandom_range(0, 2097152)) - 1048576;
        end else if (mode < 6) begin
          // straddle the half-box fold point
          delta = {1'b0, forces_sb.box_len[a] >> 1} + $signed($urandom_range(0, 2)) - 1;
          p[a] = $urandom_range(0, 1) ? ref_v + delta : ref_v - delta;
        end else if (mode < 9) begin
          p[a] = $urandom();
        end else begin
          case ($urandom_range(0, 3))
            0: p[a] = 32'sh8000_0000;
            1: p[a] = 32'sh7FFF_FFFF;
            2: p[a] = '0;
            default: p[a] = '1;
          endcase
        end
      end
      send_item(ACT_COMPUTE, tag, p[0], p[1], p[2]);
    end
  endtask

  task automatic run_segment(bit with_hold, bit with_pause);
    for (int i = 0; i < SegItems; i++) begin
      if (with_hold && i == 120) hold_asks++;
      if (with_pause && i == 220) wait_forces_drained();
      random_item();
    end
  endtask

  task automatic directed_items();
    send_item(ACT_STORE,   12'h000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_STORE,   12'hFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(ACT_STORE,   12'hAAA, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(ACT_STORE,   12'h555, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678);
    send_item(ACT_COMPUTE, 12'h000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_COMPUTE, 12'h000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(ACT_COMPUTE, 12'h000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(ACT_COMPUTE, 12'hFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(ACT_COMPUTE, 12'hAAA, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // x box is 16.0: exactly +half folds, exactly -half does not
    send_item(ACT_COMPUTE, 12'h000, 32'h0008_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_COMPUTE, 12'h000, 32'hFFF8_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_COMPUTE, 12'h000, 32'hFFF7_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_COMPUTE, 12'h000, 32'h0007_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_COMPUTE, 12'h555, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678);
    send_item(ACT_COMPUTE, 12'h555, 32'h0001_0001, 32'hFFFF_0001, 32'h1234_5679);
    send_item(ACT_STORE,   12'h555, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_COMPUTE, 12'h555, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    // y force around the saturation edge at full stiffness
    send_item(ACT_COMPUTE, 12'h000, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
    send_item(ACT_COMPUTE, 12'h000, 32'h0000_0000, 32'hFFFF_8000, 32'h0000_0000);
    send_item(ACT_COMPUTE, 12'h000, 32'h0000_0000, 32'h0000_8001, 32'h0000_0000);
    send_item(ACT_COMPUTE, 12'h000, 32'h0000_0000, 32'hFFFF_7FFF, 32'h0000_0000);
    // z: unit stiffness, |dr| = 2^31 in both directions
    send_item(ACT_COMPUTE, 12'hAAA, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_COMPUTE, 12'hFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.action       = ACT_COMPUTE;
    in_if.particle_tag = '0;
    in_if.pos_x        = '0;
    in_if.pos_y        = '0;
    in_if.pos_z        = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_STIFF_X;
    cfg_if.data        = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 18;
    recv_idle_pct = 54;
    configure(32'h0001_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0010_0000, '0, '0);
    directed_items();
    run_segment(1'b1, 1'b0);
    wait_forces_drained();
    configure($urandom_range(0, 32'h4_0000), $urandom_range(0, 32'h4_0000),
              $urandom_range(0, 32'h4_0000), $urandom_range(32'h1_0000, 32'h400_0000),
              $urandom_range(32'h1_0000, 32'h400_0000), $urandom_range(32'h1_0000, 32'h400_0000));
    run_segment(1'b0, 1'b1);

    send_idle_pct = 54;
    recv_idle_pct = 18;
    wait_forces_drained();
    configure('1, '1, '1, '0, '0, '0);
    run_segment(1'b1, 1'b0);
    wait_forces_drained();
    configure('0, '0, '0, '1, '1, '1);
    run_segment(1'b0, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_forces_drained();
    configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    run_segment(1'b1, 1'b0);
    wait_forces_drained();
    configure(32'h0000_0001, 32'h0000_8000, 32'h0002_0000, 32'h0001_0000, 32'h2, 32'h1);
    run_segment(1'b0, 1'b0);

    wait_forces_drained();
    if (forces_sb.pending() != 0) begin
      $error("%0d force results never arrived", forces_sb.pending());
      forces_sb.errors++;
    end
    $display("Covered %0d reference stores and %0d checked force results over six settings",
             forces_sb.n_stores, forces_sb.n_results);
    $display("with %0d box folds and %0d saturated force components, %0d mismatches.",
             forces_sb.n_wraps, forces_sb.n_sat, forces_sb.errors);
    if (forces_sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: harmonic_position_restraint_top.f
sv/hpr_pkg.sv
sv/hpr_if.sv
sv/hpr_lane.sv
sv/hpr_merge.sv
sv/harmonic_position_restraint_top.sv
test/tb_top.sv
